>>> src/wdt_pkg.sv
// Shared types and constants for the watchdog timer register block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package wdt_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int PRE_W  = 8;
    localparam int DIV_W  = 7;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    // Register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_RELOAD = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_COUNT  = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_CLEAR  = 4'd12;

    // Control word bits and fields
    localparam int CTRL_EN_BIT  = 5;
    localparam int CTRL_IRQ_BIT = 2;
    localparam int CTRL_RST_BIT = 0;
    localparam int CTRL_PRE_LO  = 8;
    localparam int CTRL_DIV_LO  = 3;

    localparam logic [DATA_W-1:0] CTRL_RESET   = 32'h0000_8021;
    localparam logic [DATA_W-1:0] RELOAD_RESET = 32'h0000_8000;

    typedef enum logic [1:0] {
        DIV_16  = 2'd0,
        DIV_32  = 2'd1,
        DIV_64  = 2'd2,
        DIV_128 = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              reset_request;
    } t_result;

    // Last divider count before it wraps
    function automatic logic [DIV_W-1:0] div_terminal(input logic [1:0] sel);
        logic [DIV_W-1:0] term;
        case (t_div_sel'(sel))
            DIV_16:  term = 7'd15;
            DIV_32:  term = 7'd31;
            DIV_64:  term = 7'd63;
            DIV_128: term = 7'd127;
            default: term = 7'd127;
        endcase
        return term;
    endfunction

endpackage

>>> src/watchdog_timer_registers_unit.sv
// Top level of the watchdog timer register block: input register, core, result register.
// Depends on wdt_pkg, wdt_in_reg, wdt_core and wdt_out_reg.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+----------------------------------------
//  slave    | in  | i_s_tvalid/o_s_tready | tuser mode, tdata address, write_data
//  master   | out | o_m_tvalid/i_m_tready | tdata read_data, irq_level, reset_request
//
// One beat in, one beat out. A beat is taken every cycle unless a master-side stall
// holds the input register; each result passes the input and then the result register.
// The combinational path is the core next-state logic (down-count compare and
// decrement, prescaler and divider compares) between the two registers.
// Reset (synchronous, i_rst_n low) empties both stages and restores register defaults.
// A stall on the master side holds the result register and then the input register.
`timescale 1ns / 1ps

module watchdog_timer_registers_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [3:0] address, [35:4] write_data, [39:36] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [31:0] read_data, [32] irq_level,
                                     // [33] reset_request, [39:34] zero
);
    import wdt_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    fire;
    t_result core_result;
    t_result out_result;

    // unpack the slave beat
    assign in_item.mode       = i_s_tuser;
    assign in_item.address    = i_s_tdata[ADDR_W-1:0];
    assign in_item.write_data = i_s_tdata[ADDR_W +: DATA_W];

    wdt_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // commit state only when the held beat moves into the result register
    assign fire = stage_valid && advance;

    wdt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    wdt_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (stage_valid),
        .i_result  (core_result),
        .i_ready   (i_m_tready),
        .o_advance (advance),
        .o_valid   (o_m_tvalid),
        .o_result  (out_result)
    );

    // pack the master beat
    assign o_m_tdata = {6'd0, out_result.reset_request, out_result.irq_level,
                        out_result.read_data};

endmodule

>>> src/wdt_in_reg.sv
// Input register stage: captures one beat from the slave-side stream.
// Depends on wdt_pkg for the item type.
`timescale 1ns / 1ps

module wdt_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  wdt_pkg::t_item  i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output wdt_pkg::t_item  o_item
);
    import wdt_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/wdt_core.sv
// Watchdog state (registers, prescaler, divider, down counter) and the
// per-beat next-state and result logic. Depends on wdt_pkg.
`timescale 1ns / 1ps

module wdt_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wdt_pkg::t_item    i_item,
    output wdt_pkg::t_result  o_result
);
    import wdt_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(RELOAD_RESET);
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = COUNT_WIDTH'(1);

    logic [DATA_W-1:0]      r_ctrl, n_ctrl;
    logic [DATA_W-1:0]      r_reload, n_reload;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_running, n_running;
    logic                   r_irq, n_irq;
    logic [PRE_W-1:0]       r_pre, n_pre;
    logic [DIV_W-1:0]       r_div, n_div;

    logic [PRE_W-1:0] pre_end;
    logic [DIV_W-1:0] div_end;
    logic [DATA_W-1:0] rd_data;
    logic              rst_req;

    assign pre_end = r_ctrl[CTRL_PRE_LO +: PRE_W];
    assign div_end = div_terminal(r_ctrl[CTRL_DIV_LO +: 2]);

    always_comb begin
        n_ctrl    = r_ctrl;
        n_reload  = r_reload;
        n_count   = r_count;
        n_running = r_running;
        n_irq     = r_irq;
        n_pre     = r_pre;
        n_div     = r_div;
        rd_data   = '0;
        rst_req   = 1'b0;
        case (t_mode'(i_item.mode))
            MODE_TICK: begin
                if (r_running) begin
                    if (r_pre < pre_end) begin
                        n_pre = r_pre + 1'b1;
                    end else begin
                        n_pre = '0;
                        if (r_div < div_end) begin
                            n_div = r_div + 1'b1;
                        end else begin
                            n_div = '0;
                            if (r_count > COUNT_ONE) begin
                                n_count = r_count - COUNT_ONE;
                            end else if (r_ctrl[CTRL_IRQ_BIT]) begin
                                n_irq   = 1'b1;
                                n_count = r_reload[COUNT_WIDTH-1:0];
                            end else begin
                                n_count   = '0;
                                n_running = 1'b0;
                                rst_req   = r_ctrl[CTRL_RST_BIT];
                            end
                        end
                    end
                end
            end
            MODE_READ: begin
                case (i_item.address)
                    ADDR_CTRL:   rd_data = r_ctrl;
                    ADDR_RELOAD: rd_data = r_reload;
                    ADDR_COUNT:  rd_data = DATA_W'(r_count);
                    default:     rd_data = '0;
                endcase
            end
            MODE_WRITE: begin
                case (i_item.address)
                    ADDR_CTRL: begin
                        // rising enable restarts from reload, falling enable stops
                        if (i_item.write_data[CTRL_EN_BIT] && !r_ctrl[CTRL_EN_BIT]) begin
                            n_count   = r_reload[COUNT_WIDTH-1:0];
                            n_pre     = '0;
                            n_div     = '0;
                            n_running = 1'b1;
                        end
                        if (!i_item.write_data[CTRL_EN_BIT] && r_ctrl[CTRL_EN_BIT]) begin
                            n_running = 1'b0;
                        end
                        n_ctrl = i_item.write_data;
                    end
                    ADDR_RELOAD: n_reload = i_item.write_data;
                    ADDR_COUNT: begin
                        n_count = i_item.write_data[COUNT_WIDTH-1:0];
                        if (!r_ctrl[CTRL_EN_BIT]) begin
                            n_running = 1'b0;
                        end
                    end
                    ADDR_CLEAR: n_irq = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= CTRL_RESET;
            r_reload  <= RELOAD_RESET;
            r_count   <= COUNT_RESET;
            r_running <= 1'b0;
            r_irq     <= 1'b0;
            r_pre     <= '0;
            r_div     <= '0;
        end else if (i_fire) begin
            r_ctrl    <= n_ctrl;
            r_reload  <= n_reload;
            r_count   <= n_count;
            r_running <= n_running;
            r_irq     <= n_irq;
            r_pre     <= n_pre;
            r_div     <= n_div;
        end
    end

    assign o_result.read_data     = rd_data;
    assign o_result.irq_level     = n_irq;
    assign o_result.reset_request = rst_req;

    a_rst_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && rst_req) |=> !r_running)
        else $error("reset request did not stop the watchdog");

    a_rst_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rst_req |-> (i_item.mode == MODE_TICK && r_running && r_count <= COUNT_ONE))
        else $error("reset request outside an expiring tick");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == MODE_TICK && !r_running) |=>
            ($stable(r_count) && $stable(r_pre) && $stable(r_div)))
        else $error("stopped watchdog advanced on a tick");

    a_read_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == MODE_READ) |=>
            ($stable(r_irq) && $stable(r_count) && $stable(r_running)))
        else $error("bus read changed watchdog state");

endmodule

>>> src/wdt_out_reg.sv
// Result register stage: holds one result beat for the master-side stream.
// Depends on wdt_pkg for the result type.
`timescale 1ns / 1ps

module wdt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wdt_pkg::t_result  i_result,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output wdt_pkg::t_result  o_result
);
    import wdt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // room when empty or when the held beat leaves this cycle
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
